### design/pups_pkg.sv
// ----------------------------------------------------------------------------
// Supervisor package
// Shared types, codes and reset constants of the power-up supervisor.
// ----------------------------------------------------------------------------
package pups_pkg;

  localparam int NUM_ERROR_COUNTERS_DEF = 2;
  localparam int COUNTER_W              = 16;
  localparam int CFG_DATA_W             = 16;
  localparam int CFG_INDEX_W            = 2;
  localparam int TIME_W                 = 32;
  localparam int LIGHT_W                = 12;
  localparam int S_TDATA_W              = 48;
  localparam int S_TUSER_W              = 3;
  localparam int M_TDATA_W              = 24;

  localparam logic [CFG_DATA_W-1:0] POWER_OFF_MS_RST = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] LIMIT_TIME_RST   = 16'd4;
  localparam logic [CFG_DATA_W-1:0] LIMIT_OTHER_RST  = 16'd1;
  localparam logic [COUNTER_W-1:0]  COUNTER_MAX      = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POWER_OFF_MS = 2'd0,
    REG_LIMIT_TIME   = 2'd1,
    REG_LIMIT_OTHER  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_RUN   = 2'd0,
    CMD_INC   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_COUNTER = 2'd1,
    FAULT_TASK    = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_WAIT     = 3'd1,
    PH_CNT      = 3'd2,
    PH_TASK     = 3'd3,
    PH_ANNOUNCE = 3'd4,
    PH_HALT     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] power_off_ms;
    logic [CFG_DATA_W-1:0] limit_time_errors;
    logic [CFG_DATA_W-1:0] limit_other_errors;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         command;
    logic               counter_index;
    logic [TIME_W-1:0]  time_ms;
    logic               task_overflow;
    logic [LIGHT_W-1:0] light_sample;
    logic               motion_sample;
  } item_t;

  // packed so that power_off_pin lands in bit 0
  typedef struct packed {
    logic [2:0]         phase;
    logic               motion_value;
    logic [LIGHT_W-1:0] light_value;
    logic               fault_counter;
    logic [1:0]         fault_source;
    logic               power_is_on;
    logic               watchdog_pin;
    logic               power_off_pin;
  } result_t;

endpackage

### design/pups_cfg_regs.sv
// ----------------------------------------------------------------------------
// Supervisor configuration registers
// Write-only register file: power-off time and the two counter limits.
// ----------------------------------------------------------------------------
module pups_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [pups_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pups_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pups_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_off_ms       <= pups_pkg::POWER_OFF_MS_RST;
      cfg.limit_time_errors  <= pups_pkg::LIMIT_TIME_RST;
      cfg.limit_other_errors <= pups_pkg::LIMIT_OTHER_RST;
    end else if (cfg_wr_en) begin
      case (pups_pkg::reg_index_t'(cfg_index))
        pups_pkg::REG_POWER_OFF_MS: cfg.power_off_ms       <= cfg_data;
        pups_pkg::REG_LIMIT_TIME:   cfg.limit_time_errors  <= cfg_data;
        pups_pkg::REG_LIMIT_OTHER:  cfg.limit_other_errors <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### design/pups_engine.sv
// ----------------------------------------------------------------------------
// Supervisor engine
// Phase machine, error counters and captured samples; updates once per
// transaction and presents the result built from the updated state.
// ----------------------------------------------------------------------------
module pups_engine #(
  parameter int NUM_ERROR_COUNTERS = pups_pkg::NUM_ERROR_COUNTERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  pups_pkg::item_t   item,
  input  pups_pkg::cfg_t    cfg,
  output pups_pkg::result_t res_next
);

  pups_pkg::phase_t phase_reg, phase_next;
  logic [pups_pkg::TIME_W-1:0]    deadline, deadline_next;
  logic [pups_pkg::COUNTER_W-1:0] counters [NUM_ERROR_COUNTERS];
  logic                           kick_level, kick_next;
  logic                           power_hold, hold_next;
  logic [pups_pkg::LIGHT_W-1:0]   light_store, light_next;
  logic                           motion_store, motion_next;
  logic [1:0]                     fault_code, fault_code_next;
  logic                           fault_index, fault_index_next;
  logic                           cnt_hit;
  logic                           hit_idx;
  logic                           run;

  assign run = (item.command == pups_pkg::CMD_RUN);

  // one counter per slot; an index beyond the counter count matches none
  for (genvar i = 0; i < NUM_ERROR_COUNTERS; i++) begin : g_cnt
    logic sel;
    assign sel = (int'(item.counter_index) == i);
    always_ff @(posedge clk) begin
      if (rst) begin
        counters[i] <= '0;
      end else if (en && sel) begin
        if (item.command == pups_pkg::CMD_INC && counters[i] != pups_pkg::COUNTER_MAX) begin
          counters[i] <= counters[i] + 1'b1;
        end else if (item.command == pups_pkg::CMD_CLEAR) begin
          counters[i] <= '0;
        end
      end
    end
  end

  always_comb begin
    logic [pups_pkg::COUNTER_W-1:0] lim;
    cnt_hit = 1'b0;
    hit_idx = 1'b0;
    lim     = '0;
    // lowest index wins
    for (int i = 0; i < NUM_ERROR_COUNTERS; i++) begin
      lim = (i == 0) ? cfg.limit_time_errors : cfg.limit_other_errors;
      if (!cnt_hit && counters[i] >= lim) begin
        cnt_hit = 1'b1;
        hit_idx = 1'(i);
      end
    end
  end

  always_comb begin
    phase_next       = phase_reg;
    deadline_next    = deadline;
    kick_next        = kick_level;
    hold_next        = power_hold;
    light_next       = light_store;
    motion_next      = motion_store;
    fault_code_next  = fault_code;
    fault_index_next = fault_index;
    if (run) begin
      case (phase_reg)
        pups_pkg::PH_START: begin
          hold_next     = 1'b1;
          deadline_next = item.time_ms +
                          {{(pups_pkg::TIME_W-pups_pkg::CFG_DATA_W){1'b0}}, cfg.power_off_ms};
          phase_next    = pups_pkg::PH_WAIT;
        end
        pups_pkg::PH_WAIT: begin
          if (item.time_ms > deadline) begin
            hold_next  = 1'b0;
            phase_next = pups_pkg::PH_CNT;
          end
        end
        pups_pkg::PH_CNT: begin
          light_next  = item.light_sample;
          motion_next = item.motion_sample;
          if (cnt_hit) begin
            fault_code_next  = pups_pkg::FAULT_COUNTER;
            fault_index_next = hit_idx;
            phase_next       = pups_pkg::PH_ANNOUNCE;
          end else begin
            kick_next  = ~kick_level;
            phase_next = pups_pkg::PH_TASK;
          end
        end
        pups_pkg::PH_TASK: begin
          if (item.task_overflow) begin
            fault_code_next = pups_pkg::FAULT_TASK;
            phase_next      = pups_pkg::PH_ANNOUNCE;
          end else begin
            kick_next  = ~kick_level;
            phase_next = pups_pkg::PH_CNT;
          end
        end
        pups_pkg::PH_ANNOUNCE: phase_next = pups_pkg::PH_HALT;
        pups_pkg::PH_HALT:     phase_next = pups_pkg::PH_HALT;
        default:               phase_next = pups_pkg::PH_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= pups_pkg::PH_START;
      deadline     <= '0;
      kick_level   <= 1'b0;
      power_hold   <= 1'b0;
      light_store  <= '0;
      motion_store <= 1'b0;
      fault_code   <= pups_pkg::FAULT_NONE;
      fault_index  <= 1'b0;
    end else if (en) begin
      phase_reg    <= phase_next;
      deadline     <= deadline_next;
      kick_level   <= kick_next;
      power_hold   <= hold_next;
      light_store  <= light_next;
      motion_store <= motion_next;
      fault_code   <= fault_code_next;
      fault_index  <= fault_index_next;
    end
  end

  always_comb begin
    res_next.power_off_pin = hold_next;
    res_next.watchdog_pin  = kick_next;
    res_next.power_is_on   = (phase_next != pups_pkg::PH_START);
    res_next.fault_source  = fault_code_next;
    res_next.fault_counter = (fault_code_next == pups_pkg::FAULT_COUNTER) ?
                             fault_index_next : 1'b0;
    res_next.light_value   = light_next;
    res_next.motion_value  = motion_next;
    res_next.phase         = phase_next;
  end

endmodule

### design/power_up_supervisor_watchdog_core.sv
// ----------------------------------------------------------------------------
// Power-up supervisor and watchdog
// Top level: input register, configuration registers, supervisor engine, result register.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries commands: run a supervisor step, bump or clear an error
//   counter. Every transaction gives exactly one result transaction on m_*,
//   showing power hold, watchdog level, phase, fault and captured samples
//   after that command.
//   cfg_* writes the power-off time and the two counter limits; write only
//   while no transaction is in flight.
//   m_tvalid rises once the s_* transaction has passed the input register
//   and its result has entered the result register. One transaction per
//   cycle is sustained while m_tready is high; the phase machine and
//   counter compares sit in one combinational stage between those two registers.
//   Reset empties both registers, returns the configuration to its defaults
//   and clears all supervisor state. While m_tready is low the result is
//   held, an empty input register still takes one more transaction, and
//   s_tready then stays low until the result leaves.
// ----------------------------------------------------------------------------
module power_up_supervisor_watchdog_core #(
  parameter int NUM_ERROR_COUNTERS = pups_pkg::NUM_ERROR_COUNTERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // time_ms[31:0], task_overflow[32], light_sample[44:33], motion_sample[45]
  input  logic [pups_pkg::S_TDATA_W-1:0]   s_tdata,
  // command[1:0], counter_index[2]
  input  logic [pups_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // power_off_pin[0], watchdog_pin[1], power_is_on[2], fault_source[4:3],
  // fault_counter[5], light_value[17:6], motion_value[18], phase[21:19]
  output logic [pups_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                             cfg_wr_en,
  input  logic [pups_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pups_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pups_pkg::cfg_t    cfg;
  pups_pkg::item_t   in_item;
  pups_pkg::result_t res_next;
  pups_pkg::result_t res;
  logic              in_valid;
  logic              advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command       <= s_tuser[1:0];
      in_item.counter_index <= s_tuser[2];
      in_item.time_ms       <= s_tdata[31:0];
      in_item.task_overflow <= s_tdata[32];
      in_item.light_sample  <= s_tdata[44:33];
      in_item.motion_sample <= s_tdata[45];
    end
  end

  pups_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pups_engine #(
    .NUM_ERROR_COUNTERS (NUM_ERROR_COUNTERS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .item     (in_item),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(pups_pkg::M_TDATA_W - $bits(pups_pkg::result_t)){1'b0}}, res};

endmodule

### design/pups_checker.sv
// ----------------------------------------------------------------------------
// Supervisor port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
module pups_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pups_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [2:0] ph;
  logic [1:0] fsrc;

  assign ph   = m_tdata[21:19];
  assign fsrc = m_tdata[4:3];

  // result held under back-pressure
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // power is held off exactly in the wait phase, and on from then on
  a_power: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (ph == pups_pkg::PH_WAIT)) &&
                 (m_tdata[2] == (ph != pups_pkg::PH_START)))
    else $error("power pins disagree with phase");

  a_fault_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((fsrc != pups_pkg::FAULT_NONE) ==
                  (ph == pups_pkg::PH_ANNOUNCE || ph == pups_pkg::PH_HALT)))
    else $error("fault source disagrees with phase");

  a_fault_counter: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> fsrc == pups_pkg::FAULT_COUNTER)
    else $error("fault counter set without counter fault");

endmodule

bind power_up_supervisor_watchdog_core pups_checker u_pups_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
